### rtl/tiny_language_lexer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiny language lexer
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TINY_LANGUAGE_LEXER_MACROS_SVH
`define TINY_LANGUAGE_LEXER_MACROS_SVH

// property must hold at every clock edge out of reset
`define TLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen at a clock edge out of reset
`define TLL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/tll_pkg.sv
// ----------------------------------------------------------------------------
// tll_pkg
// Types, token codes and character constants of the tiny language lexer.
// ----------------------------------------------------------------------------
package tll_pkg;

  // sizing
  localparam int MaxIdChars = 8;
  localparam int NumberBits = 32;
  localparam int CharW      = 8;
  localparam int KindW      = 5;
  localparam int ValueW     = 32;
  localparam int TextW      = 64;
  localparam int LenW       = 4;
  localparam int NumKw      = 8;
  localparam int NumOps     = 11;

  // token queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // saturation limits of the number accumulator
  localparam logic [NumberBits-1:0] NumMax      = '1;
  localparam logic [NumberBits-1:0] NumMaxDiv10 = NumMax / 10;
  localparam logic [3:0]            NumMaxMod10 = 4'(NumMax % 10);

  // scanner mode
  typedef enum logic [2:0] {
    ModeStart,
    ModeNum,
    ModeId,
    ModeColon,
    ModeComment
  } mode_e;

  // token kinds
  typedef enum logic [KindW-1:0] {
    KindIdent, KindNumber, KindAssign,
    KindIf, KindThen, KindElse, KindEnd, KindRepeat, KindUntil, KindRead, KindWrite,
    KindPlus, KindMinus, KindStar, KindSlash, KindEqual, KindLess, KindSemi,
    KindLparen, KindRparen, KindLbrack, KindRbrack,
    KindUnknown, KindBadNum, KindBadAssign
  } kind_e;

  // characters
  localparam logic [CharW-1:0] ChColon  = 8'h3A;
  localparam logic [CharW-1:0] ChLbrace = 8'h7B;
  localparam logic [CharW-1:0] ChRbrace = 8'h7D;
  localparam logic [CharW-1:0] ChEq     = 8'h3D;
  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChCr     = 8'h0D;
  localparam logic [CharW-1:0] ChLf     = 8'h0A;

  // keywords, first character in the low byte, in kind order from KindIf
  localparam logic [TextW-1:0] KwText [NumKw] = '{
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6E65_6874,  // then
    64'h0000_0000_6573_6C65,  // else
    64'h0000_0000_0064_6E65,  // end
    64'h0000_7461_6570_6572,  // repeat
    64'h0000_006C_6974_6E75,  // until
    64'h0000_0000_6461_6572,  // read
    64'h0000_0065_7469_7277   // write
  };
  localparam logic [LenW-1:0] KwLen [NumKw] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd4, 4'd5
  };

  // single-character operators, in kind order from KindPlus
  localparam logic [CharW-1:0] OpChars [NumOps] = '{
    8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3B, 8'h28, 8'h29, 8'h5B, 8'h5D
  };

  // one token
  typedef struct packed {
    kind_e             kind;
    logic [ValueW-1:0] value;
    logic              ovf;
    logic [TextW-1:0]  text;
    logic [LenW-1:0]   len;
    logic              trunc;
  } tok_t;

  // all tokens of one character: one or two
  typedef struct packed {
    tok_t first;
    tok_t second;
    logic two;
  } pair_t;

endpackage

### rtl/tll_if.sv
// ----------------------------------------------------------------------------
// tll_if
// Valid/ready channels of the lexer: character input and token output.
// ----------------------------------------------------------------------------

// character channel
interface tll_in_if;
  import tll_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             end_of_input;

  modport source (output valid, char_code, end_of_input, input ready);
  modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

// token channel
interface tll_out_if;
  import tll_pkg::*;

  logic              valid;
  logic              ready;
  logic [KindW-1:0]  token_kind;
  logic [ValueW-1:0] number_value;
  logic              number_overflow;
  logic [TextW-1:0]  token_text;
  logic [LenW-1:0]   text_length;
  logic              text_truncated;
  logic              last_of_run;

  modport source (output valid, token_kind, number_value, number_overflow, token_text,
                  text_length, text_truncated, last_of_run, input ready);
  modport sink   (input valid, token_kind, number_value, number_overflow, token_text,
                  text_length, text_truncated, last_of_run, output ready);
endinterface

### rtl/tiny_language_lexer.sv
// ----------------------------------------------------------------------------
// tiny_language_lexer
// Path: a character's tokens go through the pair queue to the registered output word.
// Throughput: one character a cycle while the four-entry pair queue has room;
// the output sends one word a cycle while ready is high, and a pair as two words.
// Reset: rst_ni low clears scan mode, queue pointers and output valid at once.
// ----------------------------------------------------------------------------
module tiny_language_lexer (
  input  logic      clk_i,
  input  logic      rst_ni,
  tll_in_if.sink    in_i,
  tll_out_if.source out_o
);
  import tll_pkg::*;

  logic  push, pop, full, empty;
  pair_t pair, head;

  // scanner front
  tll_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .pair_o (pair)
  );

  // token pair queue
  tll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pair_i  (pair),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // output back
  tll_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

### rtl/tll_front.sv
// ----------------------------------------------------------------------------
// tll_front
// Scanner front: takes one character a cycle while the queue is not full, tracks
// the scan mode and builds the one or two tokens that the character completes.
// ----------------------------------------------------------------------------
module tll_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  tll_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output tll_pkg::pair_t pair_o
);
  import tll_pkg::*;

  // identifier token with keyword lookup
  function automatic tok_t ident_tok(input logic [TextW-1:0] idb,
                                     input logic [LenW-1:0]  idl,
                                     input logic             idt);
    tok_t t;
    logic hit;
    t     = '0;
    t.kind = KindIdent;
    hit   = 1'b0;
    for (int k = 0; k < NumKw; k++) begin
      if (!idt && !hit && idl == KwLen[k] && idb == KwText[k]) begin
        t.kind = kind_e'(KindW'(k) + KindW'(KindIf));
        hit    = 1'b1;
      end
    end
    t.text  = idb;
    t.len   = idl;
    t.trunc = idt;
    return t;
  endfunction

  // number token
  function automatic tok_t number_tok(input logic [NumberBits-1:0] acc,
                                      input logic                  sat);
    tok_t t;
    t       = '0;
    t.kind  = KindNumber;
    t.value = ValueW'(acc);
    t.ovf   = sat;
    return t;
  endfunction

  // token carrying a short text and no value
  function automatic tok_t text_tok(input kind_e            kind,
                                    input logic [TextW-1:0] text,
                                    input logic [LenW-1:0]  len);
    tok_t t;
    t      = '0;
    t.kind = kind;
    t.text = text;
    t.len  = len;
    return t;
  endfunction

  mode_e                 mode_q, mode_d;
  logic [NumberBits-1:0] acc_q, acc_d;
  logic                  sat_q, sat_d;
  logic [TextW-1:0]      idbuf_q, idbuf_d;
  logic [LenW-1:0]       idlen_q, idlen_d;
  logic                  idtrunc_q, idtrunc_d;

  logic [CharW-1:0] ch;
  logic             eoi;
  logic             is_dig, is_let, again, op_hit;
  logic             a_v, b_v, c_v;
  tok_t             a_tok, b_tok, c_tok;
  kind_e            op_kind;
  logic             accept;

  assign ch     = in_i.char_code;
  assign eoi    = in_i.end_of_input;
  assign is_dig = (ch >= 8'h30) && (ch <= 8'h39);
  assign is_let = ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));

  // operator lookup
  always_comb begin
    op_hit  = 1'b0;
    op_kind = KindUnknown;
    for (int k = 0; k < NumOps; k++) begin
      if (!op_hit && ch == OpChars[k]) begin
        op_kind = kind_e'(KindW'(k) + KindW'(KindPlus));
        op_hit  = 1'b1;
      end
    end
  end

  // scan step: A from leaving the mode, B from a rescan in start, C from the flush
  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    sat_d     = sat_q;
    idbuf_d   = idbuf_q;
    idlen_d   = idlen_q;
    idtrunc_d = idtrunc_q;
    again     = 1'b0;
    a_v       = 1'b0;
    b_v       = 1'b0;
    c_v       = 1'b0;
    a_tok     = '0;
    b_tok     = '0;
    c_tok     = '0;

    case (mode_q)
      ModeNum: begin
        if (is_dig) begin
          if (!sat_q) begin
            if (acc_q > NumMaxDiv10 || (acc_q == NumMaxDiv10 && ch[3:0] > NumMaxMod10)) begin
              acc_d = NumMax;
              sat_d = 1'b1;
            end else begin
              acc_d = (acc_q << 3) + (acc_q << 1) + NumberBits'(ch[3:0]);
            end
          end
        end else if (is_let) begin
          a_v   = 1'b1;
          a_tok = text_tok(KindBadNum, '0, '0);
          again = 1'b1;
        end else begin
          a_v   = 1'b1;
          a_tok = number_tok(acc_q, sat_q);
          again = 1'b1;
        end
      end
      ModeId: begin
        if (is_let) begin
          if (idlen_q < LenW'(MaxIdChars)) begin
            for (int i = 0; i < TextW / CharW; i++) begin
              if (LenW'(i) == idlen_q) begin
                idbuf_d[i*CharW +: CharW] = idbuf_q[i*CharW +: CharW] | ch;
              end
            end
            idlen_d = idlen_q + 1'b1;
          end else begin
            idtrunc_d = 1'b1;
          end
        end else begin
          a_v   = 1'b1;
          a_tok = ident_tok(idbuf_q, idlen_q, idtrunc_q);
          again = 1'b1;
        end
      end
      ModeColon: begin
        a_v = 1'b1;
        if (ch == ChEq) begin
          a_tok  = text_tok(KindAssign, TextW'({ChEq, ChColon}), LenW'(2));
          mode_d = ModeStart;
        end else begin
          a_tok = text_tok(KindBadAssign, TextW'(ChColon), LenW'(1));
          again = 1'b1;
        end
      end
      ModeComment: begin
        if (ch == ChRbrace) begin
          mode_d = ModeStart;
        end
      end
      default: begin
        again = 1'b1;
      end
    endcase

    // classify the character from the start mode
    if (again) begin
      mode_d = ModeStart;
      if (is_dig) begin
        acc_d  = NumberBits'(ch[3:0]);
        sat_d  = 1'b0;
        mode_d = ModeNum;
      end else if (is_let) begin
        idbuf_d   = TextW'(ch);
        idlen_d   = LenW'(1);
        idtrunc_d = 1'b0;
        mode_d    = ModeId;
      end else if (ch == ChColon) begin
        mode_d = ModeColon;
      end else if (ch == ChLbrace) begin
        mode_d = ModeComment;
      end else if (ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf) begin
        mode_d = ModeStart;
      end else begin
        b_v   = 1'b1;
        b_tok = text_tok(op_kind, TextW'(ch), LenW'(1));
      end
    end

    // end of input flushes whatever is pending
    if (eoi) begin
      case (mode_d)
        ModeNum: begin
          c_v   = 1'b1;
          c_tok = number_tok(acc_d, sat_d);
        end
        ModeId: begin
          c_v   = 1'b1;
          c_tok = ident_tok(idbuf_d, idlen_d, idtrunc_d);
        end
        ModeColon: begin
          c_v   = 1'b1;
          c_tok = text_tok(KindBadAssign, TextW'(ChColon), LenW'(1));
        end
        default: begin
          c_v = 1'b0;
        end
      endcase
      mode_d = ModeStart;
    end
  end

  // pack the tokens in order; B and C never occur together
  always_comb begin
    pair_o.first  = a_v ? a_tok : (b_v ? b_tok : c_tok);
    pair_o.second = b_v ? b_tok : c_tok;
    pair_o.two    = a_v && (b_v || c_v);
  end

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept && (a_v || b_v || c_v);

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeStart;
      acc_q     <= '0;
      sat_q     <= 1'b0;
      idbuf_q   <= '0;
      idlen_q   <= '0;
      idtrunc_q <= 1'b0;
    end else if (accept) begin
      mode_q    <= mode_d;
      acc_q     <= acc_d;
      sat_q     <= sat_d;
      idbuf_q   <= idbuf_d;
      idlen_q   <= idlen_d;
      idtrunc_q <= idtrunc_d;
    end
  end

endmodule

### rtl/tll_queue.sv
// ----------------------------------------------------------------------------
// tll_queue
// Short FIFO of token pairs between the scanner front and the output back.
// ----------------------------------------------------------------------------
`include "tiny_language_lexer_macros.svh"

module tll_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tll_pkg::pair_t pair_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output tll_pkg::pair_t head_o
);
  import tll_pkg::*;

  pair_t            entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= pair_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `TLL_ASSERT_NEVER(a_push_full, push_i && full_o, "token pair pushed into a full queue")
  `TLL_ASSERT_NEVER(a_pop_empty, pop_i && empty_o, "token pair popped from an empty queue")
  `TLL_ASSERT(a_cnt_range, cnt_q <= QCntW'(QDepth), "queue fill count out of range")

endmodule

### rtl/tll_back.sv
// ----------------------------------------------------------------------------
// tll_back
// Output back: takes token pairs from the queue and sends one word a cycle
// if not stalled, via a registered output; marks each character's last word.
// ----------------------------------------------------------------------------
`include "tiny_language_lexer_macros.svh"

module tll_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  tll_pkg::pair_t head_i,
  output logic           pop_o,
  tll_out_if.source      out_o
);
  import tll_pkg::*;

  logic out_valid_q, out_valid_d;
  tok_t out_tok_q, out_tok_d;
  logic out_last_q, out_last_d;
  logic sec_pend_q, sec_pend_d;
  tok_t sec_tok_q, sec_tok_d;
  logic load;

  // output slot is free when empty or its word is being taken
  assign load  = !out_valid_q || out_o.ready;
  assign pop_o = load && !sec_pend_q && !empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_tok_d   = out_tok_q;
    out_last_d  = out_last_q;
    sec_pend_d  = sec_pend_q;
    sec_tok_d   = sec_tok_q;
    if (load) begin
      if (sec_pend_q) begin
        out_valid_d = 1'b1;
        out_tok_d   = sec_tok_q;
        out_last_d  = 1'b1;
        sec_pend_d  = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        out_tok_d   = head_i.first;
        out_last_d  = !head_i.two;
        sec_pend_d  = head_i.two;
        sec_tok_d   = head_i.second;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_pend_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sec_pend_q  <= sec_pend_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    out_tok_q  <= out_tok_d;
    out_last_q <= out_last_d;
    sec_tok_q  <= sec_tok_d;
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.token_kind      = out_tok_q.kind;
  assign out_o.number_value    = out_tok_q.value;
  assign out_o.number_overflow = out_tok_q.ovf;
  assign out_o.token_text      = out_tok_q.text;
  assign out_o.text_length     = out_tok_q.len;
  assign out_o.text_truncated  = out_tok_q.trunc;
  assign out_o.last_of_run     = out_last_q;

  `TLL_ASSERT(a_pend_shown, sec_pend_q |-> out_valid_q, "second token pending with no word out")
  `TLL_ASSERT(a_pend_last, out_valid_q |-> (sec_pend_q == !out_last_q), "last mark mismatch")
  `TLL_ASSERT(a_valid_hold, out_valid_q && !out_o.ready |=> out_valid_q, "word dropped in stall")

endmodule
